// ===== design/asfbc_pkg.sv =====
// Shared types and constants of the Alamouti SFBC pilot encoder.
package asfbc_pkg;

    // Q1.14 scaling by sqrt(2) on pilot pairs
    localparam int SQRT2_Q14   = 23170;
    localparam int SQRT2_W     = 16;
    localparam int SQRT2_FRAC  = 14;

    localparam int MAX_PILOTS  = 16;
    localparam int MAX_SYMBOL  = 4096;

    localparam int SYM_LEN_W    = 13;
    localparam int PILOT_CNT_W  = 5;
    localparam int PILOT_WORD_W = 48;
    localparam int PILOT_FLD_W  = 12;
    localparam int PILOTS_PER_W = 4;
    localparam int PILOT_WORDS  = 4;
    localparam int POS_W        = 11;
    localparam int PIDX_W       = 5;
    localparam int PAIRS_W      = 12;
    localparam int CFG_ADDR_W   = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SYMBOL_LENGTH = 3'd0,
        REG_PILOT_COUNT   = 3'd1,
        REG_PILOT_WORD_0  = 3'd2,
        REG_PILOT_WORD_1  = 3'd3,
        REG_PILOT_WORD_2  = 3'd4,
        REG_PILOT_WORD_3  = 3'd5
    } cfg_reg_t;

    // Per-pair decision handed from the sequencer to the data path
    typedef struct packed {
        logic is_pilot;
        logic last;
    } pair_info_t;

endpackage

// ===== design/asfbc_ctrl.sv =====
// Configuration registers, pair/pilot counters and pilot-pair detection.
module asfbc_ctrl (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [asfbc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [asfbc_pkg::PILOT_WORD_W-1:0]      cfg_wr_data,
    input  logic                                    advance,
    output asfbc_pkg::pair_info_t                   info
);

    logic [asfbc_pkg::SYM_LEN_W-1:0]   sym_len_reg;
    logic [asfbc_pkg::PILOT_CNT_W-1:0] pilot_cnt_reg;
    logic [asfbc_pkg::PILOT_WORDS-1:0][asfbc_pkg::PILOTS_PER_W-1:0]
          [asfbc_pkg::PILOT_FLD_W-1:0] pilot_reg;

    logic [asfbc_pkg::POS_W-1:0]  pos_reg,  pos_next;
    logic [asfbc_pkg::PIDX_W-1:0] pidx_reg, pidx_next;

    logic [asfbc_pkg::SYM_LEN_W-1:0]   len_clamp;
    logic [asfbc_pkg::PAIRS_W-1:0]     pairs;
    logic [asfbc_pkg::PILOT_CNT_W-1:0] pc_clamp;
    logic [asfbc_pkg::PILOT_FLD_W-1:0] entry;
    logic                              pilot_hit;
    logic                              last_pair;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_len_reg   <= asfbc_pkg::SYM_LEN_W'(64);
            pilot_cnt_reg <= '0;
            pilot_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (asfbc_pkg::cfg_reg_t'(cfg_addr))
                asfbc_pkg::REG_SYMBOL_LENGTH: begin
                    sym_len_reg <= cfg_wr_data[asfbc_pkg::SYM_LEN_W-1:0];
                end
                asfbc_pkg::REG_PILOT_COUNT: begin
                    pilot_cnt_reg <= cfg_wr_data[asfbc_pkg::PILOT_CNT_W-1:0];
                end
                asfbc_pkg::REG_PILOT_WORD_0: begin
                    pilot_reg[0] <= cfg_wr_data;
                end
                asfbc_pkg::REG_PILOT_WORD_1: begin
                    pilot_reg[1] <= cfg_wr_data;
                end
                asfbc_pkg::REG_PILOT_WORD_2: begin
                    pilot_reg[2] <= cfg_wr_data;
                end
                asfbc_pkg::REG_PILOT_WORD_3: begin
                    pilot_reg[3] <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        // clamp the symbol length, then count pairs (never fewer than one)
        len_clamp = (sym_len_reg > asfbc_pkg::SYM_LEN_W'(asfbc_pkg::MAX_SYMBOL))
                  ? asfbc_pkg::SYM_LEN_W'(asfbc_pkg::MAX_SYMBOL) : sym_len_reg;
        pairs = len_clamp[asfbc_pkg::SYM_LEN_W-1:1];
        if (pairs == '0) begin
            pairs = asfbc_pkg::PAIRS_W'(1);
        end
        pc_clamp = (pilot_cnt_reg > asfbc_pkg::PILOT_CNT_W'(asfbc_pkg::MAX_PILOTS))
                 ? asfbc_pkg::PILOT_CNT_W'(asfbc_pkg::MAX_PILOTS) : pilot_cnt_reg;

        entry     = pilot_reg[pidx_reg[3:2]][pidx_reg[1:0]];
        pilot_hit = (pidx_reg < pc_clamp) && (entry == {pos_reg, 1'b0});
        last_pair = (asfbc_pkg::PAIRS_W'(pos_reg) + asfbc_pkg::PAIRS_W'(1)) >= pairs;

        if (last_pair) begin
            pos_next  = '0;
            pidx_next = '0;
        end else begin
            pos_next  = pos_reg + asfbc_pkg::POS_W'(1);
            pidx_next = pidx_reg + asfbc_pkg::PIDX_W'(pilot_hit);
        end

        info.is_pilot = pilot_hit;
        info.last     = last_pair;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            pidx_reg <= '0;
        end else if (advance) begin
            pos_reg  <= pos_next;
            pidx_reg <= pidx_next;
        end
    end

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && info.last |=> pos_reg == '0 && pidx_reg == '0)
        else $error("counters not cleared after last pair of symbol");

    a_pidx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pidx_reg <= asfbc_pkg::PIDX_W'(asfbc_pkg::MAX_PILOTS))
        else $error("pilot index ran past the pilot list");

endmodule

// ===== design/asfbc_mapper.sv =====
// Alamouti pair mapping: negation, conjugation, sqrt2 pilot scaling, saturation.
module asfbc_mapper #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic signed [SAMPLE_WIDTH-1:0] even_re,
    input  logic signed [SAMPLE_WIDTH-1:0] even_im,
    input  logic signed [SAMPLE_WIDTH-1:0] odd_re,
    input  logic signed [SAMPLE_WIDTH-1:0] odd_im,
    input  logic                           is_pilot,
    output logic signed [SAMPLE_WIDTH-1:0] ant0_even_re,
    output logic signed [SAMPLE_WIDTH-1:0] ant0_even_im,
    output logic signed [SAMPLE_WIDTH-1:0] ant0_odd_re,
    output logic signed [SAMPLE_WIDTH-1:0] ant0_odd_im,
    output logic signed [SAMPLE_WIDTH-1:0] ant1_even_re,
    output logic signed [SAMPLE_WIDTH-1:0] ant1_even_im,
    output logic signed [SAMPLE_WIDTH-1:0] ant1_odd_re,
    output logic signed [SAMPLE_WIDTH-1:0] ant1_odd_im
);

    localparam int EW   = SAMPLE_WIDTH + 1;
    localparam int PW   = EW + asfbc_pkg::SQRT2_W;
    localparam logic signed [PW-1:0] K   = PW'(asfbc_pkg::SQRT2_Q14);
    localparam logic signed [PW-1:0] RND = PW'(1 << (asfbc_pkg::SQRT2_FRAC - 1));
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // clip an extended sample back to SAMPLE_WIDTH
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_ext(
        input logic signed [EW-1:0] v
    );
        if (v[EW-1] != v[EW-2]) begin
            return v[EW-1] ? S_MIN : S_MAX;
        end
        return v[SAMPLE_WIDTH-1:0];
    endfunction

    // multiply by sqrt2, round half up, clip
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_scl(
        input logic signed [EW-1:0] v
    );
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] s;
        p = PW'(v) * K;
        s = (p + RND) >>> asfbc_pkg::SQRT2_FRAC;
        if (s[PW-1:SAMPLE_WIDTH-1] != {(PW-SAMPLE_WIDTH+1){s[PW-1]}}) begin
            return s[PW-1] ? S_MIN : S_MAX;
        end
        return s[SAMPLE_WIDTH-1:0];
    endfunction

    logic signed [EW-1:0] r0, i0, r1, i1, nr1, ni0;

    always_comb begin
        r0  = EW'(even_re);
        i0  = EW'(even_im);
        r1  = EW'(odd_re);
        i1  = EW'(odd_im);
        nr1 = -r1;
        ni0 = -i0;

        if (is_pilot) begin
            ant0_even_re = sat_scl(r0);
            ant0_even_im = sat_scl(i0);
            ant0_odd_re  = sat_scl(nr1);
            ant0_odd_im  = sat_scl(i1);
            ant1_even_re = '0;
            ant1_even_im = '0;
            ant1_odd_re  = '0;
            ant1_odd_im  = '0;
        end else begin
            ant0_even_re = sat_ext(r0);
            ant0_even_im = sat_ext(i0);
            ant0_odd_re  = sat_ext(nr1);
            ant0_odd_im  = sat_ext(i1);
            ant1_even_re = sat_ext(r1);
            ant1_even_im = sat_ext(i1);
            ant1_odd_re  = sat_ext(r0);
            ant1_odd_im  = sat_ext(ni0);
        end
    end

endmodule

// ===== design/alamouti_sfbc_pilot_encoder_top.sv =====
// Top level of the two-antenna Alamouti SFBC encoder with pilot pairs.
// A pair goes through the input register, then through the mapping and sqrt2 multipliers
//   into the output register.
// Throughput: one pair per cycle; s_axis_tready drops only while both registers
//   hold a pair and m_axis_tready is low.
// Reset (aresetn low, synchronous): pipeline empty, counters zero, symbol_length 64, rest 0.
module alamouti_sfbc_pilot_encoder_top #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [asfbc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [asfbc_pkg::PILOT_WORD_W-1:0]  cfg_wr_data,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // even_re, even_im, odd_re, odd_im (lowest first), zero pad to bytes
    input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // ant0_even_re, ant0_even_im, ant0_odd_re, ant0_odd_im,
    // ant1_even_re, ant1_even_im, ant1_odd_re, ant1_odd_im (lowest first)
    output logic [8*SAMPLE_WIDTH-1:0]           m_axis_tdata,
    // is_pilot
    output logic                                m_axis_tuser,
    // last_of_symbol
    output logic                                m_axis_tlast
);

    localparam int SW = SAMPLE_WIDTH;

    // Input stage: samples plus the pilot/last decision taken at acceptance
    logic                  s1_valid_reg;
    logic signed [SW-1:0]  s1_even_re_reg, s1_even_im_reg;
    logic signed [SW-1:0]  s1_odd_re_reg,  s1_odd_im_reg;
    asfbc_pkg::pair_info_t s1_info_reg;

    // Output stage
    logic                  m_valid_reg;
    logic [8*SW-1:0]       m_data_reg;
    asfbc_pkg::pair_info_t m_info_reg;

    asfbc_pkg::pair_info_t pair_info;
    logic                  out_rdy;
    logic                  s_accept;
    logic signed [SW-1:0]  a0_er, a0_ei, a0_or, a0_oi, a1_er, a1_ei, a1_or, a1_oi;

    // Output register frees when empty or being taken; input stage moves on then
    assign out_rdy       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_rdy;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Counters advance once per accepted transaction
    asfbc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .advance     (s_accept),
        .info        (pair_info)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    // Payload needs no reset; load only on a transaction
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_even_re_reg <= s_axis_tdata[0*SW +: SW];
            s1_even_im_reg <= s_axis_tdata[1*SW +: SW];
            s1_odd_re_reg  <= s_axis_tdata[2*SW +: SW];
            s1_odd_im_reg  <= s_axis_tdata[3*SW +: SW];
            s1_info_reg    <= pair_info;
        end
    end

    asfbc_mapper #(
        .SAMPLE_WIDTH (SW)
    ) u_mapper (
        .even_re      (s1_even_re_reg),
        .even_im      (s1_even_im_reg),
        .odd_re       (s1_odd_re_reg),
        .odd_im       (s1_odd_im_reg),
        .is_pilot     (s1_info_reg.is_pilot),
        .ant0_even_re (a0_er),
        .ant0_even_im (a0_ei),
        .ant0_odd_re  (a0_or),
        .ant0_odd_im  (a0_oi),
        .ant1_even_re (a1_er),
        .ant1_even_im (a1_ei),
        .ant1_odd_re  (a1_or),
        .ant1_odd_im  (a1_oi)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_rdy) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    // Hold the result until taken; advance the input stage into it otherwise
    always_ff @(posedge aclk) begin
        if (out_rdy && s1_valid_reg) begin
            m_data_reg <= {a1_oi, a1_or, a1_ei, a1_er, a0_oi, a0_or, a0_ei, a0_er};
            m_info_reg <= s1_info_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_info_reg.is_pilot;
    assign m_axis_tlast  = m_info_reg.last;

    a_pilot_ant1_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_info_reg.is_pilot |-> m_data_reg[8*SW-1:4*SW] == '0)
        else $error("antenna 1 not silent on a pilot pair");

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_rdy |=> s1_valid_reg && $stable(s1_even_re_reg)
            && $stable(s1_odd_im_reg) && $stable(s1_info_reg))
        else $error("input stage lost a transaction while the output stalled");

    a_out_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && out_rdy |=> m_valid_reg)
        else $error("input stage advanced without filling the output register");

endmodule

// ===== tb/alamouti_pair_checker.sv =====
// Checker that predicts every coded subcarrier pair of the SFBC encoder and compares it.
module alamouti_pair_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [asfbc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [asfbc_pkg::PILOT_WORD_W-1:0]  cfg_wr_data,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // even_re, even_im, odd_re, odd_im (lowest first)
    input  logic [63:0]                         s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // ant0_even_re .. ant0_odd_im, ant1_even_re .. ant1_odd_im (lowest first)
    input  logic [127:0]                        m_axis_tdata,
    // is_pilot
    input  logic                                m_axis_tuser,
    // last_of_symbol
    input  logic                                m_axis_tlast,
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  pairs_checked,
    output int                                  pilots_checked,
    output int                                  symbols_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic         pilot;
        logic         last;
        logic [127:0] lanes;
    } coded_pair_t;

    logic [asfbc_pkg::SYM_LEN_W-1:0]    sym_len_q;
    logic [asfbc_pkg::PILOT_CNT_W-1:0]  pilot_cnt_q;
    logic [asfbc_pkg::PILOT_WORD_W-1:0] pilot_word_q [asfbc_pkg::PILOT_WORDS];
    logic [asfbc_pkg::POS_W-1:0]        pair_pos_q;
    logic [asfbc_pkg::PIDX_W-1:0]       pilot_idx_q;

    coded_pair_t coded_pairs_due [$];
    coded_pair_t want;
    string       lane_names [8] = '{"ant0_even_re", "ant0_even_im", "ant0_odd_re",
                                    "ant0_odd_im", "ant1_even_re", "ant1_even_im",
                                    "ant1_odd_re", "ant1_odd_im"};

    initial begin
        mismatches      = 0;
        pairs_checked   = 0;
        pilots_checked  = 0;
        symbols_checked = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [15:0] saturate(input longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return 16'(v);
    endfunction

    // Q1.14 multiply by sqrt2, rounding half towards plus infinity
    function automatic longint times_root2(input longint v);
        return (v * asfbc_pkg::SQRT2_Q14 + (longint'(1) << (asfbc_pkg::SQRT2_FRAC - 1)))
               >>> asfbc_pkg::SQRT2_FRAC;
    endfunction

    function automatic coded_pair_t encode_pair(input logic [63:0] d);
        longint      x0r, x0i, x1r, x1i;
        int unsigned len, pairs, pc;
        logic [11:0] entry;
        coded_pair_t c;
        x0r = longint'($signed(d[15:0]));
        x0i = longint'($signed(d[31:16]));
        x1r = longint'($signed(d[47:32]));
        x1i = longint'($signed(d[63:48]));
        len = (sym_len_q > asfbc_pkg::MAX_SYMBOL) ? asfbc_pkg::MAX_SYMBOL : sym_len_q;
        pairs = len >> 1;
        if (pairs == 0) pairs = 1;
        pc = (pilot_cnt_q > asfbc_pkg::MAX_PILOTS) ? asfbc_pkg::MAX_PILOTS : pilot_cnt_q;
        entry = 12'(pilot_word_q[pilot_idx_q[3:2]]
                    >> (asfbc_pkg::PILOT_FLD_W * pilot_idx_q[1:0]));
        c.pilot = (pilot_idx_q < pc) && (entry == {pair_pos_q, 1'b0});
        if (c.pilot) begin
            c.lanes[15:0]   = saturate(times_root2(x0r));
            c.lanes[31:16]  = saturate(times_root2(x0i));
            c.lanes[47:32]  = saturate(times_root2(-x1r));
            c.lanes[63:48]  = saturate(times_root2(x1i));
            c.lanes[127:64] = '0;
            pilot_idx_q = pilot_idx_q + 1'b1;
        end else begin
            c.lanes[15:0]    = saturate(x0r);
            c.lanes[31:16]   = saturate(x0i);
            c.lanes[47:32]   = saturate(-x1r);
            c.lanes[63:48]   = saturate(x1i);
            c.lanes[79:64]   = saturate(x1r);
            c.lanes[95:80]   = saturate(x1i);
            c.lanes[111:96]  = saturate(x0r);
            c.lanes[127:112] = saturate(-x0i);
        end
        c.last = (pair_pos_q + 1 >= pairs);
        if (c.last) begin
            pair_pos_q  = '0;
            pilot_idx_q = '0;
        end else begin
            pair_pos_q = pair_pos_q + 1'b1;
        end
        return c;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            sym_len_q   = asfbc_pkg::SYM_LEN_W'(64);
            pilot_cnt_q = '0;
            for (int w = 0; w < asfbc_pkg::PILOT_WORDS; w++) pilot_word_q[w] = '0;
            pair_pos_q  = '0;
            pilot_idx_q = '0;
            coded_pairs_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    asfbc_pkg::REG_SYMBOL_LENGTH:
                        sym_len_q = cfg_wr_data[asfbc_pkg::SYM_LEN_W-1:0];
                    asfbc_pkg::REG_PILOT_COUNT:
                        pilot_cnt_q = cfg_wr_data[asfbc_pkg::PILOT_CNT_W-1:0];
                    asfbc_pkg::REG_PILOT_WORD_0:  pilot_word_q[0] = cfg_wr_data;
                    asfbc_pkg::REG_PILOT_WORD_1:  pilot_word_q[1] = cfg_wr_data;
                    asfbc_pkg::REG_PILOT_WORD_2:  pilot_word_q[2] = cfg_wr_data;
                    asfbc_pkg::REG_PILOT_WORD_3:  pilot_word_q[3] = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                coded_pairs_due.push_back(encode_pair(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (coded_pairs_due.size() == 0) begin
                    report_mismatch($sformatf("coded pair with none due, tdata %h",
                                              m_axis_tdata));
                end else begin
                    want = coded_pairs_due.pop_front();
                    for (int k = 0; k < 8; k++) begin
                        if (m_axis_tdata[16*k +: 16] !== want.lanes[16*k +: 16]) begin
                            report_mismatch($sformatf("pair %0d %s got %h want %h",
                                pairs_checked, lane_names[k], m_axis_tdata[16*k +: 16],
                                want.lanes[16*k +: 16]));
                        end
                    end
                    if (m_axis_tuser !== want.pilot) begin
                        report_mismatch($sformatf("pair %0d is_pilot got %b want %b",
                                                  pairs_checked, m_axis_tuser, want.pilot));
                    end
                    if (m_axis_tlast !== want.last) begin
                        report_mismatch($sformatf("pair %0d last_of_symbol got %b want %b",
                                                  pairs_checked, m_axis_tlast, want.last));
                    end
                    pairs_checked++;
                    if (want.pilot) pilots_checked++;
                    if (want.last) symbols_checked++;
                end
            end
        end
        outstanding <= coded_pairs_due.size();
    end

endmodule

// ===== tb/alamouti_sfbc_pilot_encoder_top_test.sv =====
// Stimulus and verdict for the Alamouti SFBC pilot encoder, checked by a separate checker.
module alamouti_sfbc_pilot_encoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 11;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_SETTINGS = 12;
    localparam int PAIRS_PER_SET   = 70;
    localparam int LONG_RUN_PAIRS  = 240;
    // far longer than any correct run takes
    localparam longint TIMEOUT_NS  = 5_000_000;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [asfbc_pkg::CFG_ADDR_W-1:0]   cfg_addr;
    logic [asfbc_pkg::PILOT_WORD_W-1:0] cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // even_re, even_im, odd_re, odd_im (lowest first)
    logic [63:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // ant0_even_re, ant0_even_im, ant0_odd_re, ant0_odd_im,
    // ant1_even_re, ant1_even_im, ant1_odd_re, ant1_odd_im (lowest first)
    logic [127:0] m_axis_tdata;
    // is_pilot
    logic         m_axis_tuser;
    // last_of_symbol
    logic         m_axis_tlast;

    int mismatches, outstanding, pairs_checked, pilots_checked, symbols_checked;

    // idling knobs, in percent
    int gap_pct   = 0;
    int stall_pct = 0;
    // hold-off requests: the receiver process honours each new request once
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left  = 0;
    int settings_used = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    alamouti_sfbc_pilot_encoder_top #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    alamouti_pair_checker pair_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .pairs_checked   (pairs_checked),
        .pilots_checked  (pilots_checked),
        .symbols_checked (symbols_checked)
    );

    // Receiver: stall at random, or hold off for a long stretch when asked.
    // A new request is picked up at the next edge and counted down here alone.
    always @(posedge aclk) begin
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Pick the idling pattern of a phase: none, sender gaps, receiver stalls, both.
    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 49; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 49; end
            default: begin gap_pct = 20; stall_pct = 20; end
        endcase
    endtask

    // Register write: the enable is high for a single cycle and then goes low before the task returns,
    // so that back-to-back writes never drive the enable twice in one step.
    task automatic write_reg(input asfbc_pkg::cfg_reg_t idx,
                             input logic [asfbc_pkg::PILOT_WORD_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    // Pack sixteen 12-bit pilot indices, low field first, into the four words.
    task automatic load_pilots(input logic [11:0] plist [16]);
        for (int w = 0; w < asfbc_pkg::PILOT_WORDS; w++) begin
            write_reg(asfbc_pkg::cfg_reg_t'(int'(asfbc_pkg::REG_PILOT_WORD_0) + w),
                      {plist[4*w+3], plist[4*w+2], plist[4*w+1], plist[4*w]});
        end
    endtask

    function automatic logic [63:0] pack_pair(input int even_r, input int even_i,
                                              input int odd_r, input int odd_i);
        return {16'(odd_i), 16'(odd_r), 16'(even_i), 16'(even_r)};
    endfunction

    // Mostly uniform samples, with the corner values now and then.
    function automatic logic [15:0] rand_sample();
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(5))
                0: return 16'h8000;
                1: return 16'h8001;
                2: return 16'h7fff;
                3: return 16'h0000;
                4: return 16'hffff;
                default: return 16'h0001;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic logic [63:0] rand_pair();
        return {rand_sample(), rand_sample(), rand_sample(), rand_sample()};
    endfunction

    // Offer one pair; optionally idle first. Leave tvalid high after the
    // transaction so that the next pair can follow without a gap.
    task automatic send_pair(input logic [63:0] d);
        if ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Drop tvalid, wait for every due pair to come back, then let the
    // two-stage pipeline run dry before anything touches the registers.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Draw a fresh setting: short, odd, oversized or ordinary symbol lengths,
    // pilot counts past the limit now and then, and pilot lists that are
    // ascending, carry an odd entry, are out of order or are pure noise.
    task automatic random_setting();
        int len, pc, p, kind, a, b;
        logic [11:0] plist [16];
        logic [11:0] tmp;
        logic [asfbc_pkg::PILOT_WORD_W-1:0] value;
        case ($urandom_range(9))
            0: len = $urandom_range(0, 1);
            1: len = 2 * $urandom_range(1, 20) + 1;
            2: len = $urandom_range(asfbc_pkg::MAX_SYMBOL + 1, 8191);
            3: len = 2 * $urandom_range(20, 60);
            default: len = 2 * $urandom_range(1, 16);
        endcase
        pc = ($urandom_range(7) == 0) ? $urandom_range(asfbc_pkg::MAX_PILOTS + 1, 31)
                                      : $urandom_range(0, asfbc_pkg::MAX_PILOTS);
        // junk above each register's width must be ignored
        value = {16'($urandom), 32'($urandom)};
        value[asfbc_pkg::SYM_LEN_W-1:0] = asfbc_pkg::SYM_LEN_W'(len);
        write_reg(asfbc_pkg::REG_SYMBOL_LENGTH, value);
        value = {16'($urandom), 32'($urandom)};
        value[asfbc_pkg::PILOT_CNT_W-1:0] = asfbc_pkg::PILOT_CNT_W'(pc);
        write_reg(asfbc_pkg::REG_PILOT_COUNT, value);

        p = $urandom_range(0, 2);
        for (int i = 0; i < 16; i++) begin
            plist[i] = 12'(2 * p);
            p += $urandom_range(1, 3);
            if (p > 2047) p = 2047;
        end
        kind = $urandom_range(5);
        case (kind)
            3: plist[$urandom_range(15)][0] = 1'b1;
            4: begin
                a = $urandom_range(0, 7);
                b = $urandom_range(8, 15);
                tmp = plist[a];
                plist[a] = plist[b];
                plist[b] = tmp;
            end
            5: for (int i = 0; i < 16; i++) plist[i] = 12'($urandom);
            default: ;
        endcase
        load_pilots(plist);
        settings_used++;
    endtask

    // Watchdog: end the run if it hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [11:0] plist [16];
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_addr      <= asfbc_pkg::REG_SYMBOL_LENGTH;
        cfg_wr_data   <= '0;
        aresetn       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: data pairs under the reset setting, sample extremes and
        // the saturating negations.
        send_pair(pack_pair(0, 0, 0, 0));
        send_pair(pack_pair(32767, 32767, 32767, 32767));
        send_pair(pack_pair(-32768, -32768, -32768, -32768));
        send_pair(pack_pair(1, -1, -32768, 32767));
        settle();

        // Shorten the symbol while four pairs in: the next pair must end it.
        // Pilots then sit on even subcarriers 0 and 4.
        for (int i = 0; i < 16; i++) plist[i] = '0;
        plist[1] = 12'd4;
        write_reg(asfbc_pkg::REG_SYMBOL_LENGTH, 48'd8);
        write_reg(asfbc_pkg::REG_PILOT_COUNT, 48'd2);
        load_pilots(plist);
        settings_used++;
        send_pair(pack_pair(100, -200, 300, -400));
        send_pair(pack_pair(32767, -32768, -32768, 32767));   // pilot, saturates
        send_pair(pack_pair(-32768, 32767, 32767, -32768));
        send_pair(pack_pair(1, -1, 1, -1));                   // pilot, rounding
        send_pair(pack_pair(2, -2, -3, 3));
        send_pair(pack_pair(-32768, -32768, -32768, -32768)); // pilot
        send_pair(pack_pair(7, -7, 5, -5));
        send_pair(pack_pair(3, -3, 23170, -23170));           // pilot
        send_pair(pack_pair(0, 0, 0, 0));
        settle();

        // Odd length rounds down to one pair: every pair is a pilot and last.
        write_reg(asfbc_pkg::REG_SYMBOL_LENGTH, 48'd3);
        write_reg(asfbc_pkg::REG_PILOT_COUNT, 48'd1);
        settings_used++;
        send_pair(pack_pair(32767, 32767, -32768, -32768));
        send_pair(pack_pair(-1, 1, -1, 1));
        send_pair(pack_pair(16384, -16384, 11585, -11585));
        settle();

        // Length below two still counts as one pair.
        write_reg(asfbc_pkg::REG_SYMBOL_LENGTH, 48'd0);
        write_reg(asfbc_pkg::REG_PILOT_COUNT, 48'd0);
        settings_used++;
        send_pair(pack_pair(-32768, 0, 32767, 0));
        send_pair(pack_pair(0, -32768, 0, 32767));
        settle();

        // Random settings, cycling through the idling patterns. On the third
        // one the receiver holds off for a long stretch while the sender
        // keeps offering, so the pipeline fills and back-pressures the input.
        for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
            set_idling(ph);
            random_setting();
            for (int n = 0; n < PAIRS_PER_SET; n++) begin
                if (ph == 2 && n == 10) hold_asked++;
                send_pair(rand_pair());
            end
            settle();
        end

        // Close whatever symbol is open, then run the opening part of a symbol
        // at the largest size, written oversized, with an oversized pilot count.
        set_idling(3);
        write_reg(asfbc_pkg::REG_SYMBOL_LENGTH, 48'd1);
        send_pair(rand_pair());
        settle();
        for (int i = 0; i < 15; i++) plist[i] = 12'(24 * i);
        plist[15] = 12'd4094;
        write_reg(asfbc_pkg::REG_SYMBOL_LENGTH, 48'd8191);
        write_reg(asfbc_pkg::REG_PILOT_COUNT, 48'd20);
        load_pilots(plist);
        settings_used++;
        for (int n = 0; n < LONG_RUN_PAIRS; n++) begin
            if (n == 100) hold_asked++;
            send_pair(rand_pair());
        end
        settle();

        $display("Coverage: %0d coded pairs (%0d pilot pairs, %0d symbol ends)",
                 pairs_checked, pilots_checked, symbols_checked);
        $display("Over %0d settings, idling mixed, two long output hold-offs; mismatches: %0d",
                 settings_used, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
